### design/i2ctrb_pkg.sv
`default_nettype none

package i2ctrb_pkg;

	// Default number of registers in the bank
	localparam int unsigned BANK_SIZE_DEF = 16;

	// Width of the raw register index and of a wrapped table entry
	localparam int unsigned RAW_IDX_W = 4;

	// Item kinds on the input channel
	typedef enum logic [1:0] {
		OP_START       = 2'd0,
		OP_SHIFT       = 2'd1,
		OP_LOCAL_WRITE = 2'd2,
		OP_LOCAL_READ  = 2'd3
	} op_t;

	// Next shift action named by each result
	typedef enum logic [2:0] {
		ACT_NONE       = 3'd0,
		ACT_SEND_ACK   = 3'd1,
		ACT_SAMPLE_ACK = 3'd2,
		ACT_SEND_BYTE  = 3'd3,
		ACT_RECEIVE    = 3'd4,
		ACT_RELEASE    = 3'd5
	} action_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_OWN_ADDRESS  = 3'd0,
		CFG_READ_MASK_LO = 3'd1,
		CFG_READ_MASK_HI = 3'd2,
		CFG_WRITE_MASK_LO = 3'd3,
		CFG_WRITE_MASK_HI = 3'd4
	} cfg_index_t;

	// Configuration registers as seen by the protocol logic
	typedef struct packed {
		logic [6:0]  own_address;
		logic [63:0] read_mask_lo;
		logic [63:0] read_mask_hi;
		logic [63:0] write_mask_lo;
		logic [63:0] write_mask_hi;
	} cfg_t;

	// Byte value to bank index, modulo the bank size
	typedef logic [255:0][RAW_IDX_W-1:0] wrap_tab_t;

	// Build the modulo table by repeated subtraction at elaboration
	function automatic wrap_tab_t build_wrap_tab(input int unsigned size);
		wrap_tab_t   t;
		int unsigned r;
		for (int unsigned v = 0; v < 256; v++) begin
			r = v;
			for (int unsigned k = 0; k < 256; k++) begin
				if (r >= size) begin
					r = r - size;
				end
			end
			t[v] = RAW_IDX_W'(r);
		end
		return t;
	endfunction

	// Pick the mask byte of one register from its lo/hi word pair
	function automatic logic [7:0] mask_byte(input logic [63:0] lo, input logic [63:0] hi,
			input logic [RAW_IDX_W-1:0] r);
		logic [63:0] w;
		w = r[3] ? hi : lo;
		return w[{r[2:0], 3'b000} +: 8];
	endfunction

endpackage

`default_nettype wire

### design/i2ctrb_bank.sv
`default_nettype none

module i2ctrb_bank #(
	parameter int unsigned BANK_SIZE = i2ctrb_pkg::BANK_SIZE_DEF,
	localparam int unsigned IDX_W = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// write port
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire logic [7:0]       wr_data,
	// two read ports, captured together when rd_load is high
	input  wire logic             rd_load,
	input  wire logic [IDX_W-1:0] ptr_addr,
	input  wire logic [IDX_W-1:0] idx_addr,
	output logic      [7:0]       ptr_data_q,
	output logic      [7:0]       idx_data_q
);

	logic [7:0]           mem [BANK_SIZE];
	logic [BANK_SIZE-1:0] valid_q;

	// Store written bytes
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Mark entries written since reset; an unmarked entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Capture both read ports, passing through a write at the same edge
	always_ff @(posedge clk) begin
		if (rd_load) begin
			if (wr_en && (wr_addr == ptr_addr)) begin
				ptr_data_q <= wr_data;
			end else begin
				ptr_data_q <= valid_q[ptr_addr] ? mem[ptr_addr] : 8'h00;
			end
			if (wr_en && (wr_addr == idx_addr)) begin
				idx_data_q <= wr_data;
			end else begin
				idx_data_q <= valid_q[idx_addr] ? mem[idx_addr] : 8'h00;
			end
		end
	end

endmodule

`default_nettype wire

### design/i2ctrb_ctrl.sv
`default_nettype none

module i2ctrb_ctrl #(
	parameter int unsigned BANK_SIZE = i2ctrb_pkg::BANK_SIZE_DEF,
	localparam int unsigned IDX_W = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire i2ctrb_pkg::cfg_t    cfg,
	// input item
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire i2ctrb_pkg::op_t     in_op,
	input  wire logic [7:0]          in_rx_byte,
	input  wire logic                in_sda_high,
	input  wire logic [3:0]          in_reg_index,
	input  wire logic [7:0]          in_write_data,
	// result item
	output logic                     out_valid_q,
	input  wire logic                out_ready,
	output i2ctrb_pkg::action_t      action_q,
	output logic      [7:0]          tx_byte_q,
	output logic      [7:0]          read_data_q,
	// bank access
	output logic                     wr_en,
	output logic      [IDX_W-1:0]    wr_addr,
	output logic      [7:0]          wr_data,
	output logic                     rd_load,
	output logic      [IDX_W-1:0]    ptr_addr,
	output logic      [IDX_W-1:0]    idx_addr,
	input  wire logic [7:0]          ptr_data_q,
	input  wire logic [7:0]          idx_data_q
);

	typedef enum logic [2:0] {
		PH_NONE          = 3'd0,
		PH_CHECK_ADDRESS = 3'd1,
		PH_SEND_DATA     = 3'd2,
		PH_REQUEST_REPLY = 3'd3,
		PH_CHECK_REPLY   = 3'd4,
		PH_REQUEST_DATA  = 3'd5,
		PH_GET_DATA      = 3'd6
	} phase_t;

	localparam i2ctrb_pkg::wrap_tab_t WRAP_TAB = i2ctrb_pkg::build_wrap_tab(BANK_SIZE);
	localparam logic [IDX_W:0] BANK_LIMIT = (IDX_W + 1)'(BANK_SIZE);

	// input register
	logic                valid_s1;
	i2ctrb_pkg::op_t     op_s1;
	logic [7:0]          rx_s1;
	logic                sda_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [7:0]          wd_s1;

	// protocol state
	phase_t              phase_q;
	logic [IDX_W-1:0]    pointer_q;
	logic                expect_q;
	logic                events_q;

	// next values
	phase_t              phase_d;
	logic [IDX_W-1:0]    pointer_d;
	logic                expect_d;
	logic                events_d;
	i2ctrb_pkg::action_t action_d;
	logic [7:0]          tx_d;
	logic [7:0]          rd_d;

	logic                fire_s1;
	logic                in_fire;
	logic                send_now;
	logic [IDX_W:0]      ptr_inc;
	logic [IDX_W-1:0]    ptr_next;
	logic [7:0]          rmask;
	logic [7:0]          wmask;
	logic [IDX_W-1:0]    in_idx_wrapped;

	// Advance the input register when the result register is free or drains
	assign fire_s1  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;
	assign in_fire  = in_valid && in_ready;

	assign in_idx_wrapped = IDX_W'(WRAP_TAB[{4'h0, in_reg_index}]);

	// Auto-increment with wrap at the bank size
	assign ptr_inc  = (IDX_W + 1)'(pointer_q) + (IDX_W + 1)'(1);
	assign ptr_next = (ptr_inc >= BANK_LIMIT) ? '0 : IDX_W'(ptr_inc);

	assign rmask = i2ctrb_pkg::mask_byte(cfg.read_mask_lo, cfg.read_mask_hi,
		i2ctrb_pkg::RAW_IDX_W'(pointer_q));
	assign wmask = i2ctrb_pkg::mask_byte(cfg.write_mask_lo, cfg.write_mask_hi,
		i2ctrb_pkg::RAW_IDX_W'(pointer_q));

	// Work out the result and next state of the item in the input register
	always_comb begin
		phase_d   = phase_q;
		pointer_d = pointer_q;
		expect_d  = expect_q;
		events_d  = events_q;
		action_d  = i2ctrb_pkg::ACT_NONE;
		tx_d      = 8'h00;
		rd_d      = 8'h00;
		send_now  = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = pointer_q;
		wr_data   = rx_s1 & ~wmask;
		if (valid_s1) begin
			case (op_s1)
				i2ctrb_pkg::OP_START: begin
					phase_d  = PH_CHECK_ADDRESS;
					expect_d = 1'b1;
					events_d = !sda_s1;
					action_d = sda_s1 ? i2ctrb_pkg::ACT_RELEASE : i2ctrb_pkg::ACT_RECEIVE;
				end
				i2ctrb_pkg::OP_SHIFT: begin
					if (events_q) begin
						case (phase_q)
							PH_CHECK_ADDRESS: begin
								if ((rx_s1 == 8'h00) || (rx_s1[7:1] == cfg.own_address)) begin
									phase_d  = rx_s1[0] ? PH_SEND_DATA : PH_REQUEST_DATA;
									action_d = i2ctrb_pkg::ACT_SEND_ACK;
								end else begin
									events_d = 1'b0;
									action_d = i2ctrb_pkg::ACT_RELEASE;
								end
							end
							PH_CHECK_REPLY: begin
								if (rx_s1 != 8'h00) begin
									events_d = 1'b0;
									action_d = i2ctrb_pkg::ACT_RELEASE;
								end else begin
									send_now = 1'b1;
								end
							end
							PH_SEND_DATA: begin
								send_now = 1'b1;
							end
							PH_REQUEST_REPLY: begin
								phase_d  = PH_CHECK_REPLY;
								action_d = i2ctrb_pkg::ACT_SAMPLE_ACK;
							end
							PH_REQUEST_DATA: begin
								phase_d  = PH_GET_DATA;
								action_d = i2ctrb_pkg::ACT_RECEIVE;
							end
							PH_GET_DATA: begin
								if (expect_q) begin
									pointer_d = IDX_W'(WRAP_TAB[rx_s1]);
									expect_d  = 1'b0;
								end else begin
									wr_en     = fire_s1;
									pointer_d = ptr_next;
								end
								phase_d  = PH_REQUEST_DATA;
								action_d = i2ctrb_pkg::ACT_SEND_ACK;
							end
							default: begin
								phase_d = phase_q;
							end
						endcase
						// Send the byte at the pointer and move on
						if (send_now) begin
							tx_d      = ptr_data_q & ~rmask;
							pointer_d = ptr_next;
							phase_d   = PH_REQUEST_REPLY;
							action_d  = i2ctrb_pkg::ACT_SEND_BYTE;
						end
					end
				end
				i2ctrb_pkg::OP_LOCAL_WRITE: begin
					wr_en   = fire_s1;
					wr_addr = idx_s1;
					wr_data = wd_s1;
				end
				default: begin
					rd_d = idx_data_q;
				end
			endcase
		end
	end

	// Read the bank for the incoming item, at the pointer it will see
	assign rd_load  = in_fire;
	assign ptr_addr = pointer_d;
	assign idx_addr = in_idx_wrapped;

	// Hold the input register, protocol state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_NONE;
			pointer_q   <= '0;
			expect_q    <= 1'b0;
			events_q    <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_d;
				pointer_q   <= pointer_d;
				expect_q    <= expect_d;
				events_q    <= events_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1  <= in_op;
			rx_s1  <= in_rx_byte;
			sda_s1 <= in_sda_high;
			idx_s1 <= in_idx_wrapped;
			wd_s1  <= in_write_data;
		end
		if (fire_s1) begin
			action_q    <= action_d;
			tx_byte_q   <= tx_d;
			read_data_q <= rd_d;
		end
	end

	// A byte goes out only with the send-byte action
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (action_q != i2ctrb_pkg::ACT_SEND_BYTE) |-> (tx_byte_q == 8'h00))
		else $error("tx_byte set without send-byte action");

	// Local read data comes only with no bus action
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (read_data_q != 8'h00) |-> (action_q == i2ctrb_pkg::ACT_NONE))
		else $error("read_data set alongside a bus action");

	// A start with SDA low enables shift events
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (op_s1 == i2ctrb_pkg::OP_START) && !sda_s1 |=> events_q)
		else $error("shift events not enabled after start");

	// The pointer stays inside the bank
	assert property (@(posedge clk) disable iff (!arst_n)
		(IDX_W + 1)'(pointer_q) < BANK_LIMIT)
		else $error("pointer beyond bank");

	// Protocol state moves only when an item completes
	assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(pointer_q) && $stable(phase_q))
		else $error("protocol state changed without an item");

endmodule

`default_nettype wire

### design/i2c_target_register_bank.sv
`default_nettype none

// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid/s_tready    tuser: op; tdata: rx_byte, sda_high, reg_index,
//                                           write_data
// m_       out        m_tvalid/m_tready    tuser: action; tdata: tx_byte, read_data
// cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while m_tready stays high; each item gives exactly one result,
// valid on m_ once it has passed through the input register and then the result register.
// The bank is read for an item as it enters the input register, at the pointer left by the
// item ahead of it; a write at the same edge is passed straight through.
// Reset clears protocol state, configuration and the bank's written marks (no clearing pass).
// A stalled result register holds one item and the input register one more before s_tready drops.
// The configuration port is always ready and must only be written while the block is idle.

module i2c_target_register_bank #(
	parameter int unsigned BANK_SIZE = i2ctrb_pkg::BANK_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // rx_byte[7:0], sda_high[8], reg_index[12:9],
	                                    // write_data[20:13], zero[23:21]
	input  wire logic [1:0]  s_tuser,   // op[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // tx_byte[7:0], read_data[15:8]
	output logic      [2:0]  m_tuser,   // action[2:0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam int unsigned IDX_W = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;

	i2ctrb_pkg::cfg_t    cfg_q;
	i2ctrb_pkg::action_t action_q;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [7:0]       wr_data;
	logic             rd_load;
	logic [IDX_W-1:0] ptr_addr;
	logic [IDX_W-1:0] idx_addr;
	logic [7:0]       ptr_data_q;
	logic [7:0]       idx_data_q;
	logic [7:0]       tx_byte_q;
	logic [7:0]       read_data_q;

	assign cfg_ready = 1'b1;

	// Take configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (i2ctrb_pkg::cfg_index_t'(cfg_index))
				i2ctrb_pkg::CFG_OWN_ADDRESS:   cfg_q.own_address   <= cfg_data[6:0];
				i2ctrb_pkg::CFG_READ_MASK_LO:  cfg_q.read_mask_lo  <= cfg_data;
				i2ctrb_pkg::CFG_READ_MASK_HI:  cfg_q.read_mask_hi  <= cfg_data;
				i2ctrb_pkg::CFG_WRITE_MASK_LO: cfg_q.write_mask_lo <= cfg_data;
				i2ctrb_pkg::CFG_WRITE_MASK_HI: cfg_q.write_mask_hi <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	i2ctrb_ctrl #(
		.BANK_SIZE(BANK_SIZE)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_op        (i2ctrb_pkg::op_t'(s_tuser)),
		.in_rx_byte   (s_tdata[7:0]),
		.in_sda_high  (s_tdata[8]),
		.in_reg_index (s_tdata[12:9]),
		.in_write_data(s_tdata[20:13]),
		.out_valid_q  (m_tvalid),
		.out_ready    (m_tready),
		.action_q     (action_q),
		.tx_byte_q    (tx_byte_q),
		.read_data_q  (read_data_q),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_load      (rd_load),
		.ptr_addr     (ptr_addr),
		.idx_addr     (idx_addr),
		.ptr_data_q   (ptr_data_q),
		.idx_data_q   (idx_data_q)
	);

	i2ctrb_bank #(
		.BANK_SIZE(BANK_SIZE)
	) u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_load   (rd_load),
		.ptr_addr  (ptr_addr),
		.idx_addr  (idx_addr),
		.ptr_data_q(ptr_data_q),
		.idx_data_q(idx_data_q)
	);

	// Pack the result item
	assign m_tuser = action_q;
	assign m_tdata = {read_data_q, tx_byte_q};

endmodule

`default_nettype wire
